@@ hw/rtl/ubfes_pkg.sv @@
// shared types and constants of the uart buffered fifo with error statistics
package ubfes_pkg;

  // request kinds carried on the input tuser
  typedef enum logic [2:0] {
    REQ_RX_FRAME   = 3'd0,
    REQ_HOST_WRITE = 3'd1,
    REQ_HOST_READ  = 3'd2,
    REQ_TX_READY   = 3'd3,
    REQ_FLUSH_RX   = 3'd4,
    REQ_FLUSH_TX   = 3'd5
  } req_t;

  // error codes for event_error and latest_error
  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_FRAME   = 2'd1;
  localparam logic [1:0] ERR_OVERRUN = 2'd2;
  localparam logic [1:0] ERR_PARITY  = 2'd3;

  // result codes
  localparam logic [1:0] RES_OK    = 2'd0;
  localparam logic [1:0] RES_FULL  = 2'd1;
  localparam logic [1:0] RES_EMPTY = 2'd2;

  localparam int unsigned REQ_W      = 3;
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 112;
  localparam int unsigned LEVEL_W    = 7;
  localparam int unsigned CNT_W      = 16;

  // commands from the controller to the datapath
  typedef struct packed {
    logic capture;  // latch the accepted input item
    logic exec;     // apply the item to rings and counters
    logic load;     // load the result register
  } cmd_t;

endpackage

@@ hw/rtl/uart_buffered_fifo_with_error_stats.sv @@
// top level of the uart buffered fifo with error statistics
//
// buffering side of a uart: a receive ring, a transmit ring and error counters.
// input channel (s_axis): one item is one event, its kind on s_axis_tuser
// (rx frame, host write, host read, tx ready, flush rx, flush tx), the byte
// and the frame, overrun and parity flags on s_axis_tdata.
// output channel (m_axis): every item gives exactly one result item with the
// popped byte, result and error codes, ring levels and all statistics.
// each item goes through capture, ring and counter update with the registered
// ring read, and result load; a new item is accepted only after the result
// of the last one has been loaded into the result register.
// the next item is taken while a result still waits on m_axis; if the
// receiver stalls, the following item waits in the load step and s_axis_tready
// stays low until the pending result is taken.
// reset (rst, synchronous) empties both rings, clears the counters and the
// latest error, and drops any pending result; ring storage is not cleared.
// s_axis_tready is low during reset and rises in the cycle after it is released.
module uart_buffered_fifo_with_error_stats #(
  parameter int unsigned RING_DEPTH = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // data_in[7:0], frame_error[8], data_overrun[9], parity_error[10], zero pad
  input  logic [15:0]  s_axis_tdata,
  // req_type[2:0]
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // data_out[7:0], data_valid[8], result_code[10:9], event_error[12:11],
  // rx_level[19:13], tx_free[26:20], total_errors[42:27],
  // overrun_total[58:43], framing_total[74:59], parity_total[90:75],
  // latest_error[92:91], sent_total[108:93], zero pad
  output logic [111:0] m_axis_tdata
);

  ubfes_pkg::cmd_t cmd;

  // sequencing of each item
  ubfes_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd)
  );

  // rings, counters and result register
  ubfes_datapath #(
    .RING_DEPTH (RING_DEPTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .in_user  (s_axis_tuser),
    .in_data  (s_axis_tdata),
    .out_data (m_axis_tdata)
  );

endmodule

@@ hw/rtl/ubfes_ctrl.sv @@
// controller state machine: sequences capture, execute and result load
module ubfes_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ubfes_pkg::cmd_t      cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LOAD
  } state_t;

  state_t state;
  logic   load_ok;

  assign load_ok     = (state == S_LOAD) && (!out_valid || out_ready);
  assign cmd.capture = in_valid && in_ready;
  assign cmd.exec    = (state == S_EXEC);
  assign cmd.load    = load_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      in_ready  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // a new result replaces the one taken in the same cycle
      if (load_ok) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            in_ready <= 1'b0;
            state    <= S_EXEC;
          end else begin
            in_ready <= 1'b1;
          end
        end
        S_EXEC: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          if (load_ok) begin
            in_ready <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ hw/rtl/ubfes_datapath.sv @@
// datapath: receive and transmit rings, error counters, result register
module ubfes_datapath #(
  parameter int unsigned RING_DEPTH = 64
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  ubfes_pkg::cmd_t                      cmd,
  input  logic [ubfes_pkg::REQ_W-1:0]          in_user,
  input  logic [ubfes_pkg::IN_DATA_W-1:0]      in_data,
  output logic [ubfes_pkg::OUT_DATA_W-1:0]     out_data
);

  localparam int unsigned PW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned FW = $clog2(RING_DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(RING_DEPTH - 1);
  localparam logic [FW-1:0] FILL_MAX = FW'(RING_DEPTH);
  localparam int unsigned CW = ubfes_pkg::CNT_W;

  // captured item
  ubfes_pkg::req_t req_q;
  logic [7:0]      din_q;
  logic            fe_q, dor_q, pe_q;

  // rings
  logic [7:0]    rx_mem [RING_DEPTH];
  logic [7:0]    tx_mem [RING_DEPTH];
  logic [PW-1:0] rx_rd, rx_wr, tx_rd, tx_wr;
  logic [FW-1:0] rx_fill, tx_fill;
  logic [PW-1:0] rx_rd_next, rx_wr_next, tx_rd_next, tx_wr_next;
  logic [FW-1:0] rx_fill_next, tx_fill_next;
  logic          rx_we, tx_we, rx_re, tx_re;
  logic [7:0]    rx_rdata, tx_rdata;

  // statistics
  logic [CW-1:0] cnt_total, cnt_overrun, cnt_framing, cnt_parity, cnt_sent;
  logic [CW-1:0] cnt_total_next, cnt_overrun_next, cnt_framing_next;
  logic [CW-1:0] cnt_parity_next, cnt_sent_next;
  logic [1:0]    last_err, last_err_next;

  // per item results
  logic [1:0] ev, ev_next, code, code_next;
  logic       valid, valid_next, src_tx, src_tx_next;
  logic [7:0] dout;
  logic [FW-1:0] tx_free_full;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q <= ubfes_pkg::req_t'(in_user);
      din_q <= in_data[7:0];
      fe_q  <= in_data[8];
      dor_q <= in_data[9];
      pe_q  <= in_data[10];
    end
  end

  always_comb begin
    rx_rd_next       = rx_rd;
    rx_wr_next       = rx_wr;
    rx_fill_next     = rx_fill;
    tx_rd_next       = tx_rd;
    tx_wr_next       = tx_wr;
    tx_fill_next     = tx_fill;
    rx_we            = 1'b0;
    tx_we            = 1'b0;
    rx_re            = 1'b0;
    tx_re            = 1'b0;
    cnt_total_next   = cnt_total;
    cnt_overrun_next = cnt_overrun;
    cnt_framing_next = cnt_framing;
    cnt_parity_next  = cnt_parity;
    cnt_sent_next    = cnt_sent;
    last_err_next    = last_err;
    ev_next          = ubfes_pkg::ERR_NONE;
    code_next        = ubfes_pkg::RES_OK;
    valid_next       = 1'b0;
    src_tx_next      = 1'b0;
    case (req_q)
      ubfes_pkg::REQ_RX_FRAME: begin
        if (fe_q || dor_q || pe_q) begin
          cnt_total_next = cnt_total + 1'b1;
          if (fe_q) begin
            cnt_framing_next = cnt_framing + 1'b1;
            ev_next          = ubfes_pkg::ERR_FRAME;
          end
          if (dor_q) begin
            cnt_overrun_next = cnt_overrun + 1'b1;
            ev_next          = ubfes_pkg::ERR_OVERRUN;
          end
          if (pe_q) begin
            cnt_parity_next = cnt_parity + 1'b1;
            ev_next         = ubfes_pkg::ERR_PARITY;
          end
          last_err_next = ev_next;
        end else if (rx_fill == FILL_MAX) begin
          cnt_overrun_next = cnt_overrun + 1'b1;
          ev_next          = ubfes_pkg::ERR_OVERRUN;
          last_err_next    = ubfes_pkg::ERR_OVERRUN;
          code_next        = ubfes_pkg::RES_FULL;
        end else begin
          rx_we        = 1'b1;
          rx_wr_next   = (rx_wr == PTR_LAST) ? '0 : rx_wr + 1'b1;
          rx_fill_next = rx_fill + 1'b1;
        end
      end
      ubfes_pkg::REQ_HOST_WRITE: begin
        if (tx_fill == FILL_MAX) begin
          code_next = ubfes_pkg::RES_FULL;
        end else begin
          tx_we        = 1'b1;
          tx_wr_next   = (tx_wr == PTR_LAST) ? '0 : tx_wr + 1'b1;
          tx_fill_next = tx_fill + 1'b1;
        end
      end
      ubfes_pkg::REQ_HOST_READ: begin
        if (rx_fill == '0) begin
          code_next = ubfes_pkg::RES_EMPTY;
        end else begin
          rx_re        = 1'b1;
          valid_next   = 1'b1;
          rx_rd_next   = (rx_rd == PTR_LAST) ? '0 : rx_rd + 1'b1;
          rx_fill_next = rx_fill - 1'b1;
        end
      end
      ubfes_pkg::REQ_TX_READY: begin
        if (tx_fill == '0) begin
          code_next = ubfes_pkg::RES_EMPTY;
        end else begin
          tx_re         = 1'b1;
          valid_next    = 1'b1;
          src_tx_next   = 1'b1;
          tx_rd_next    = (tx_rd == PTR_LAST) ? '0 : tx_rd + 1'b1;
          tx_fill_next  = tx_fill - 1'b1;
          cnt_sent_next = cnt_sent + 1'b1;
        end
      end
      ubfes_pkg::REQ_FLUSH_RX: begin
        rx_rd_next   = '0;
        rx_wr_next   = '0;
        rx_fill_next = '0;
      end
      ubfes_pkg::REQ_FLUSH_TX: begin
        tx_rd_next   = '0;
        tx_wr_next   = '0;
        tx_fill_next = '0;
      end
      default: begin
      end
    endcase
  end

  // ring storage, registered read
  always_ff @(posedge clk) begin
    if (cmd.exec && rx_we) begin
      rx_mem[rx_wr] <= din_q;
    end
    if (cmd.exec && rx_re) begin
      rx_rdata <= rx_mem[rx_rd];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && tx_we) begin
      tx_mem[tx_wr] <= din_q;
    end
    if (cmd.exec && tx_re) begin
      tx_rdata <= tx_mem[tx_rd];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_rd       <= '0;
      rx_wr       <= '0;
      rx_fill     <= '0;
      tx_rd       <= '0;
      tx_wr       <= '0;
      tx_fill     <= '0;
      cnt_total   <= '0;
      cnt_overrun <= '0;
      cnt_framing <= '0;
      cnt_parity  <= '0;
      cnt_sent    <= '0;
      last_err    <= ubfes_pkg::ERR_NONE;
    end else if (cmd.exec) begin
      rx_rd       <= rx_rd_next;
      rx_wr       <= rx_wr_next;
      rx_fill     <= rx_fill_next;
      tx_rd       <= tx_rd_next;
      tx_wr       <= tx_wr_next;
      tx_fill     <= tx_fill_next;
      cnt_total   <= cnt_total_next;
      cnt_overrun <= cnt_overrun_next;
      cnt_framing <= cnt_framing_next;
      cnt_parity  <= cnt_parity_next;
      cnt_sent    <= cnt_sent_next;
      last_err    <= last_err_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      ev     <= ev_next;
      code   <= code_next;
      valid  <= valid_next;
      src_tx <= src_tx_next;
    end
  end

  assign dout         = valid ? (src_tx ? tx_rdata : rx_rdata) : 8'd0;
  assign tx_free_full = FILL_MAX - tx_fill;

  // result register, fields listed from the highest bit down
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_data <= {3'd0,
                   cnt_sent,
                   last_err,
                   cnt_parity,
                   cnt_framing,
                   cnt_overrun,
                   cnt_total,
                   ubfes_pkg::LEVEL_W'(tx_free_full),
                   ubfes_pkg::LEVEL_W'(rx_fill),
                   ev,
                   code,
                   valid,
                   dout};
    end
  end

endmodule
